### hw/rtl/idll_pkg.sv
// package: shared types, operation and status codes for the indexed linked list unit
package idll_pkg;

  localparam int SLOTS = 32;
  localparam int PW = $clog2(SLOTS);
  localparam int DATA_WIDTH = 32;

  typedef enum logic [3:0] {
    OP_INS_AFTER  = 4'd0,
    OP_INS_BEFORE = 4'd1,
    OP_REMOVE     = 4'd2,
    OP_PUSH_FRONT = 4'd3,
    OP_PUSH_BACK  = 4'd4,
    OP_POP_FRONT  = 4'd5,
    OP_POP_BACK   = 4'd6,
    OP_GET        = 4'd7,
    OP_NEXT       = 4'd8,
    OP_PREV       = 4'd9,
    OP_FRONT      = 4'd10,
    OP_BACK       = 4'd11,
    OP_FIND       = 4'd12,
    OP_CLEAR      = 4'd13
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_UNUSED   = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [3:0]  operation;
    logic [4:0]  position;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  result_position;
    logic [31:0] result_value;
    logic [4:0]  element_count;
  } out_item_t;

  // datapath commands from the controller, one per state except the output state
  typedef struct packed {
    logic load;      // capture input item
    logic decide;    // check position, pick action
    logic exec;      // perform link updates
    logic walk;      // one find step
    logic sweep;     // one clear step
    logic finish;    // build the result
  } dp_cmd_t;

  typedef struct packed {
    logic is_find;
    logic is_clear;
    logic walk_done;
    logic sweep_done;
  } dp_stat_t;

endpackage

### hw/rtl/idll_ctrl.sv
// controller state machine for the indexed linked list unit
module idll_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output idll_pkg::dp_cmd_t  cmd,
  input  idll_pkg::dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_SWEEP  = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state, state_next;

  // handshake flags
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // commands
  always_comb begin
    cmd = '0;
    cmd.load   = in_valid && in_ready;
    cmd.decide = (state == S_DECIDE);
    cmd.exec   = (state == S_EXEC);
    cmd.walk   = (state == S_WALK);
    cmd.sweep  = (state == S_SWEEP);
    cmd.finish = (state == S_FINISH);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.is_find) state_next = S_WALK;
        else if (stat.is_clear) state_next = S_SWEEP;
        else state_next = S_EXEC;
      end
      S_EXEC:   state_next = S_FINISH;
      S_WALK:   if (stat.walk_done) state_next = S_FINISH;
      S_SWEEP:  if (stat.sweep_done) state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accept while result pending");

endmodule

### hw/rtl/idll_dp.sv
// datapath: slot tables, link updates, find walk and clear sweep
module idll_dp (
  input  logic                clk,
  input  logic                rst,
  input  idll_pkg::in_item_t  in_item,
  input  idll_pkg::dp_cmd_t   cmd,
  output idll_pkg::dp_stat_t  stat,
  output idll_pkg::out_item_t out_item
);

  localparam int PW = idll_pkg::PW;
  localparam int DW = idll_pkg::DATA_WIDTH;
  localparam int NS = idll_pkg::SLOTS;

  // tables (links and used bits in flops; data in a memory)
  logic [PW-1:0] next_link [NS];
  logic [PW-1:0] prev_link [NS];
  logic [NS-1:0] slot_used;
  logic [DW-1:0] slot_data [NS];
  logic [PW-1:0] free_head;
  logic [PW-1:0] count;

  // captured item and working registers
  logic [3:0]    op;
  logic [4:0]    pos;
  logic [31:0]   val;
  logic [2:0]    st;
  logic [PW-1:0] rp;
  logic [31:0]   rv;
  logic [PW-1:0] it;
  logic [PW:0]   steps;
  logic [PW-1:0] sweep_idx;
  logic [DW-1:0] rd_data;

  wire [PW-1:0] p = pos[PW-1:0];
  wire in_range = ({27'd0, pos} < NS);
  wire needs_elem = (op == idll_pkg::OP_REMOVE) || (op == idll_pkg::OP_GET) ||
                    (op == idll_pkg::OP_NEXT) || (op == idll_pkg::OP_PREV);
  wire is_ins = (op == idll_pkg::OP_INS_AFTER) || (op == idll_pkg::OP_INS_BEFORE) ||
                (op == idll_pkg::OP_PUSH_FRONT) || (op == idll_pkg::OP_PUSH_BACK);

  // check result, combinational from the captured item and registered into st in the decide cycle
  logic [2:0] chk;
  always_comb begin
    chk = idll_pkg::ST_OK;
    if (op <= 4'd1 || needs_elem) begin
      if (!in_range || (needs_elem && p == '0)) chk = idll_pkg::ST_BADPOS;
      else if (p != '0 && !slot_used[p]) chk = idll_pkg::ST_UNUSED;
    end
  end

  assign stat.is_find    = (op == idll_pkg::OP_FIND) && (chk == idll_pkg::ST_OK);
  assign stat.is_clear   = (op == idll_pkg::OP_CLEAR);
  assign stat.walk_done  = (it == '0) || (rd_data == val[DW-1:0]) || steps[PW];
  assign stat.sweep_done = (sweep_idx == PW'(NS - 1));

  // insert anchor and removal target
  logic [PW-1:0] at, tgt, nx, pv, nslot, after;
  logic pop_ok;
  always_comb begin
    case (op)
      idll_pkg::OP_INS_AFTER:  at = p;
      idll_pkg::OP_INS_BEFORE: at = prev_link[p];
      idll_pkg::OP_PUSH_FRONT: at = '0;
      default:                 at = prev_link[0];
    endcase
    nslot = free_head;
    after = next_link[at];
    tgt = (op == idll_pkg::OP_REMOVE) ? p :
          (op == idll_pkg::OP_POP_FRONT) ? next_link[0] : prev_link[0];
    nx = next_link[tgt];
    pv = prev_link[tgt];
    pop_ok = (count != '0) && (next_link[0] != '0);
  end

  // data memory: write on insert, read for get and find
  wire data_we = cmd.exec && is_ins && chk == idll_pkg::ST_OK && free_head != '0;
  wire [PW-1:0] rd_addr = cmd.walk ? next_link[it] :
                          ((cmd.decide && op == idll_pkg::OP_FIND) ? next_link[0] : p);
  always_ff @(posedge clk) begin
    if (data_we) slot_data[nslot] <= val[DW-1:0];
    rd_data <= slot_data[rd_addr];
  end

  // control and link state
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep) begin
      if (rst) sweep_idx <= '0;
      else sweep_idx <= sweep_idx + PW'(1);
      if (rst || sweep_idx == '0) begin
        free_head <= PW'(1);
        count     <= '0;
        slot_used <= {{(NS-1){1'b0}}, 1'b1};
        for (int i = 0; i < NS; i++) begin
          prev_link[i] <= '0;
          next_link[i] <= (i == 0 || i == NS - 1) ? '0 : PW'(i + 1);
        end
      end
    end else begin
      if (cmd.load) begin
        op  <= in_item.operation;
        pos <= in_item.position;
        val <= in_item.value;
        sweep_idx <= '0;
      end
      if (cmd.decide) begin
        st    <= chk;
        rp    <= '0;
        rv    <= '0;
        it    <= next_link[0];
        steps <= '0;
      end
      if (cmd.walk) begin
        if (it == '0 || steps[PW]) begin
          st <= idll_pkg::ST_NOTFOUND;
        end else if (rd_data == val[DW-1:0]) begin
          rp <= it;
        end else begin
          it    <= next_link[it];
          steps <= steps + 1'b1;
        end
      end
      if (cmd.exec && st == idll_pkg::ST_OK) begin
        case (op)
          idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE,
          idll_pkg::OP_PUSH_FRONT, idll_pkg::OP_PUSH_BACK: begin
            if (nslot == '0) begin
              st <= idll_pkg::ST_FULL;
            end else begin
              free_head <= next_link[nslot];
              prev_link[nslot] <= at;
              next_link[nslot] <= after;
              prev_link[after] <= nslot;
              next_link[at] <= nslot;
              slot_used[nslot] <= 1'b1;
              count <= count + 1'b1;
              rp <= nslot;
            end
          end
          idll_pkg::OP_REMOVE, idll_pkg::OP_POP_FRONT, idll_pkg::OP_POP_BACK: begin
            if (op != idll_pkg::OP_REMOVE && !pop_ok) begin
              st <= idll_pkg::ST_EMPTY;
            end else begin
              next_link[pv] <= nx;
              prev_link[nx] <= pv;
              prev_link[tgt] <= '0;
              slot_used[tgt] <= 1'b0;
              next_link[tgt] <= free_head;
              free_head <= tgt;
              if (count != '0) count <= count - 1'b1;
              case (op)
                idll_pkg::OP_REMOVE:    rp <= nx;
                idll_pkg::OP_POP_FRONT: rp <= (pv == '0) ? nx : next_link[0];
                default:                rp <= (nx == '0) ? pv : prev_link[0];
              endcase
            end
          end
          idll_pkg::OP_GET:  rv <= 32'(rd_data);
          idll_pkg::OP_NEXT: rp <= next_link[p];
          idll_pkg::OP_PREV: rp <= prev_link[p];
          idll_pkg::OP_FRONT, idll_pkg::OP_BACK: begin
            rp <= (op == idll_pkg::OP_FRONT) ? next_link[0] : prev_link[0];
            if (((op == idll_pkg::OP_FRONT) ? next_link[0] : prev_link[0]) == '0)
              st <= idll_pkg::ST_EMPTY;
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.status          <= st;
      out_item.result_position <= (st == idll_pkg::ST_OK) ? 5'(rp) : 5'd0;
      out_item.result_value    <= rv;
      out_item.element_count   <= 5'(count);
    end
  end

  a_sentinel_used: assert property (@(posedge clk) disable iff (rst) slot_used[0])
    else $error("sentinel slot marked free");
  a_free_unused: assert property (@(posedge clk) disable iff (rst)
    free_head != '0 |-> !slot_used[free_head])
    else $error("free chain head is in use");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.sweep) && !$past(rst) |->
    (count == $past(count) || count == $past(count) + 1'b1 ||
     count == $past(count) - 1'b1))
    else $error("count jumped");

endmodule

### hw/rtl/indexed_doubly_linked_list_unit.sv
// top level: indexed doubly linked list unit with free chain
// most operations pass from the input transfer through the decide, exec and finish states to the result
// find: the walk state visits one element per step until a match, the list end or the step limit;
// clear: the sweep state steps over every slot, the tables are rebuilt in the first sweep cycle
// one item in flight; the next input transfer is taken only after the result has been accepted
// reset (rst, synchronous) empties the list and rebuilds the free chain at once
module indexed_doubly_linked_list_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  idll_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output idll_pkg::out_item_t out_data
);

  idll_pkg::dp_cmd_t  cmd;
  idll_pkg::dp_stat_t stat;

  idll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  idll_dp u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .stat(stat),
    .out_item(out_data)
  );

endmodule

### dv/testbench.sv
// testbench: linked list unit checked against a predictor of its slot tables
`timescale 1ns / 100ps

module testbench;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  idll_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  idll_pkg::out_item_t out_data;

  indexed_doubly_linked_list_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predicted list tables
  logic [4:0]  lst_next [idll_pkg::SLOTS];
  logic [4:0]  lst_prev [idll_pkg::SLOTS];
  logic        lst_used [idll_pkg::SLOTS];
  logic [31:0] lst_data [idll_pkg::SLOTS];
  logic [4:0]  lst_free;
  int          lst_count;

  idll_pkg::out_item_t pending_results [$];
  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  quiet_cycles;

  // directed rows; expected fields checked only where chk is set
  typedef struct {
    idll_pkg::op_t       op;
    logic [4:0]          pos;
    logic [31:0]         val;
    bit                  chk;
    idll_pkg::out_item_t want;
  } row_t;

  function automatic idll_pkg::out_item_t mk(logic [2:0] s, logic [4:0] p, logic [31:0] v,
                                             logic [4:0] c);
    idll_pkg::out_item_t r;
    r.status = s; r.result_position = p; r.result_value = v; r.element_count = c;
    return r;
  endfunction

  function automatic void list_rebuild();
    for (int i = 0; i < idll_pkg::SLOTS; i++) begin
      lst_next[i] = (i + 1 < idll_pkg::SLOTS) ? 5'(i + 1) : 5'd0;
      lst_prev[i] = '0;
      lst_used[i] = 1'b0;
    end
    lst_next[0] = '0;
    lst_used[0] = 1'b1;
    lst_free = 5'd1;
    lst_count = 0;
  endfunction

  function automatic logic [4:0] list_link_after(logic [4:0] at, logic [31:0] v);
    logic [4:0] n;
    logic [4:0] aft;
    n = lst_free;
    if (n == '0) return '0;
    lst_free = lst_next[n];
    aft = lst_next[at];
    lst_prev[n] = at;
    lst_next[n] = aft;
    lst_prev[aft] = n;
    lst_next[at] = n;
    lst_used[n] = 1'b1;
    lst_data[n] = v;
    lst_count++;
    return n;
  endfunction

  function automatic void list_unlink(logic [4:0] p);
    logic [4:0] nx;
    logic [4:0] pv;
    nx = lst_next[p];
    pv = lst_prev[p];
    lst_next[pv] = nx;
    lst_prev[nx] = pv;
    lst_prev[p] = '0;
    lst_used[p] = 1'b0;
    lst_next[p] = lst_free;
    lst_free = p;
    if (lst_count > 0) lst_count--;
  endfunction

  // apply one operation to the tables and return its result
  function automatic idll_pkg::out_item_t list_apply(idll_pkg::in_item_t it);
    logic [2:0]  st;
    logic [4:0]  rp;
    logic [31:0] rv;
    logic [4:0]  at;
    logic [4:0]  walk;
    logic [3:0]  op;
    bit          needs;
    st = idll_pkg::ST_OK; rp = '0; rv = '0;
    op = it.operation;
    needs = (op == idll_pkg::OP_REMOVE || op == idll_pkg::OP_GET ||
             op == idll_pkg::OP_NEXT || op == idll_pkg::OP_PREV);
    if (op <= idll_pkg::OP_INS_BEFORE || needs) begin
      if (needs && it.position == '0) st = idll_pkg::ST_BADPOS;
      else if (it.position != '0 && !lst_used[it.position]) st = idll_pkg::ST_UNUSED;
    end
    if (st == idll_pkg::ST_OK) begin
      case (op)
        idll_pkg::OP_INS_AFTER, idll_pkg::OP_INS_BEFORE,
        idll_pkg::OP_PUSH_FRONT, idll_pkg::OP_PUSH_BACK: begin
          at = (op == idll_pkg::OP_INS_AFTER) ? it.position :
               (op == idll_pkg::OP_INS_BEFORE) ? lst_prev[it.position] :
               (op == idll_pkg::OP_PUSH_FRONT) ? 5'd0 : lst_prev[0];
          rp = list_link_after(at, it.value);
          if (rp == '0) st = idll_pkg::ST_FULL;
        end
        idll_pkg::OP_REMOVE: begin
          rp = lst_next[it.position];
          list_unlink(it.position);
        end
        idll_pkg::OP_POP_FRONT, idll_pkg::OP_POP_BACK: begin
          if (lst_count == 0 || lst_next[0] == '0) st = idll_pkg::ST_EMPTY;
          else begin
            list_unlink(op == idll_pkg::OP_POP_FRONT ? lst_next[0] : lst_prev[0]);
            rp = (op == idll_pkg::OP_POP_FRONT) ? lst_next[0] : lst_prev[0];
          end
        end
        idll_pkg::OP_GET: rv = lst_data[it.position];
        idll_pkg::OP_NEXT: rp = lst_next[it.position];
        idll_pkg::OP_PREV: rp = lst_prev[it.position];
        idll_pkg::OP_FRONT, idll_pkg::OP_BACK: begin
          rp = (op == idll_pkg::OP_FRONT) ? lst_next[0] : lst_prev[0];
          if (rp == '0) st = idll_pkg::ST_EMPTY;
        end
        idll_pkg::OP_FIND: begin
          st = idll_pkg::ST_NOTFOUND;
          walk = lst_next[0];
          for (int k = 0; k < idll_pkg::SLOTS && walk != '0; k++) begin
            if (lst_data[walk] == it.value) begin
              st = idll_pkg::ST_OK;
              rp = walk;
              break;
            end
            walk = lst_next[walk];
          end
        end
        idll_pkg::OP_CLEAR: list_rebuild();
        default: ;
      endcase
    end
    if (st != idll_pkg::ST_OK) rp = '0;
    return mk(st, rp, rv, 5'(lst_count));
  endfunction

  // pick a used element, or 0 when the list is empty
  function automatic logic [4:0] pick_used();
    logic [4:0] cand [$];
    for (int i = 1; i < idll_pkg::SLOTS; i++) if (lst_used[i]) cand.push_back(5'(i));
    if (cand.size() == 0) return '0;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  // send one transfer; prediction is made at acceptance
  task automatic send_item(idll_pkg::in_item_t it, bit chk, idll_pkg::out_item_t want);
    idll_pkg::out_item_t exp_r;
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) begin
      in_valid <= 1'b0;
      while (idle) begin
        @(posedge clk);
        idle = ($urandom_range(99) < send_idle_pct);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    exp_r = list_apply(it);
    if (chk && exp_r !== want) begin
      $display("%0t directed row mismatch: typed %h predicted %h", $time, want, exp_r);
      errors++;
    end
    pending_results.push_back(exp_r);
  endtask

  task automatic send_random();
    idll_pkg::in_item_t it;
    int r;
    r = $urandom_range(99);
    it.value = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom;
    it.position = ($urandom_range(5) == 0) ? 5'($urandom) : pick_used();
    if (r < 22)      it.operation = idll_pkg::OP_PUSH_BACK;
    else if (r < 34) it.operation = idll_pkg::OP_PUSH_FRONT;
    else if (r < 44) it.operation = idll_pkg::OP_INS_AFTER;
    else if (r < 52) it.operation = idll_pkg::OP_INS_BEFORE;
    else if (r < 60) it.operation = idll_pkg::OP_REMOVE;
    else if (r < 65) it.operation = idll_pkg::OP_POP_FRONT;
    else if (r < 70) it.operation = idll_pkg::OP_POP_BACK;
    else if (r < 99) it.operation = 4'($urandom_range(7, 12));
    else             it.operation = ($urandom_range(3) == 0) ? 4'($urandom_range(14, 15))
                                                             : idll_pkg::OP_CLEAR;
    if (it.operation == idll_pkg::OP_FIND && lst_count > 0 && $urandom_range(1)) begin
      it.position = pick_used();
      it.value = lst_data[it.position];
      it.position = 5'($urandom);
    end
    send_item(it, 1'b0, '0);
  endtask

  // drop valid and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checking
  always @(posedge clk) begin
    idll_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status)
          $display("%0t status expected %0d actual %0d", $time, e.status, out_data.status);
        if (out_data.result_position !== e.result_position)
          $display("%0t position expected %0d actual %0d", $time, e.result_position,
                   out_data.result_position);
        if (out_data.result_value !== e.result_value)
          $display("%0t value expected %h actual %h", $time, e.result_value,
                   out_data.result_value);
        if (out_data.element_count !== e.element_count)
          $display("%0t count expected %0d actual %0d", $time, e.element_count,
                   out_data.element_count);
        if (out_data !== e) errors++;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    idll_pkg::in_item_t it;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    list_rebuild();
    for (int i = 0; i < idll_pkg::SLOTS; i++) lst_data[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, every operation, errors
    rows = '{
      '{idll_pkg::OP_POP_FRONT, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_EMPTY, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_POP_BACK, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_EMPTY, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_FRONT, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_EMPTY, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_BACK, 5'd31, 32'h0, 1'b1,
        mk(idll_pkg::ST_EMPTY, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_FIND, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_NOTFOUND, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_GET, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_BADPOS, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_REMOVE, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_BADPOS, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_NEXT, 5'd31, 32'h0, 1'b1,
        mk(idll_pkg::ST_UNUSED, 5'd0, 32'd0, 5'd0)},
      '{idll_pkg::OP_PUSH_BACK, 5'd0, 32'hFFFF_FFFF, 1'b1,
        mk(idll_pkg::ST_OK, 5'd1, 32'd0, 5'd1)},
      '{idll_pkg::OP_PUSH_FRONT, 5'd31, 32'h0, 1'b1,
        mk(idll_pkg::ST_OK, 5'd2, 32'd0, 5'd2)},
      '{idll_pkg::OP_INS_AFTER, 5'd0, 32'hA5A5_5A5A, 1'b1,
        mk(idll_pkg::ST_OK, 5'd3, 32'd0, 5'd3)},
      '{idll_pkg::OP_INS_BEFORE, 5'd0, 32'h8000_0001, 1'b1,
        mk(idll_pkg::ST_OK, 5'd4, 32'd0, 5'd4)},
      '{idll_pkg::OP_GET, 5'd1, 32'h0, 1'b1,
        mk(idll_pkg::ST_OK, 5'd0, 32'hFFFF_FFFF, 5'd4)},
      '{idll_pkg::OP_INS_AFTER, 5'd20, 32'h0, 1'b1,
        mk(idll_pkg::ST_UNUSED, 5'd0, 32'd0, 5'd4)},
      '{idll_pkg::OP_INS_BEFORE, 5'd2, 32'h1234_5678, 1'b0, '0},
      '{idll_pkg::OP_NEXT, 5'd3, 32'h0, 1'b0, '0},
      '{idll_pkg::OP_PREV, 5'd3, 32'h0, 1'b0, '0},
      '{idll_pkg::OP_FIND, 5'd0, 32'h8000_0001, 1'b0, '0},
      '{idll_pkg::OP_REMOVE, 5'd3, 32'h0, 1'b0, '0},
      '{idll_pkg::OP_POP_FRONT, 5'd0, 32'h0, 1'b0, '0},
      '{idll_pkg::OP_POP_BACK, 5'd0, 32'h0, 1'b0, '0},
      '{idll_pkg::op_t'(4'd14), 5'd7, 32'hFFFF_FFFF, 1'b0, '0},
      '{idll_pkg::op_t'(4'd15), 5'd31, 32'h0, 1'b0, '0},
      '{idll_pkg::OP_CLEAR, 5'd0, 32'h0, 1'b1,
        mk(idll_pkg::ST_OK, 5'd0, 32'd0, 5'd0)}
    };
    foreach (rows[i]) begin
      it.operation = rows[i].op;
      it.position = rows[i].pos;
      it.value = rows[i].val;
      send_item(it, rows[i].chk, rows[i].want);
    end

    // fill to full and check the full error, then pause until drained
    for (int i = 0; i < idll_pkg::SLOTS; i++) begin
      it.operation = idll_pkg::OP_PUSH_BACK;
      it.position = '0;
      it.value = $urandom;
      send_item(it, 1'b0, '0);
    end
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (280) send_random();
    end

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
